/* rtl/core/qdr_pkg.sv */
// ----------------------------------------------------------------------------
// qdr_pkg
// Shared types, constants, CORDIC arctangent table and the multiply program
// of the quaternion dead-reckoning unit.
// ----------------------------------------------------------------------------
package qdr_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam logic [23:0] TIME_STEP_RESET = 24'd167772;

  localparam int DIGIT_W  = 4;
  localparam int OPND_W   = 32;
  localparam int DIGITS   = OPND_W / DIGIT_W;
  localparam int DCNT_W   = $clog2(DIGITS);
  localparam int CORD_W   = 34;

  localparam logic signed [63:0] Q30_ONE     = 64'sd1073741824;
  localparam logic signed [63:0] PI_Q28      = 64'sd843314857;
  localparam logic signed [63:0] HALF_PI_Q28 = 64'sd421657428;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam int PROG_LEN = 43;
  localparam int OP_W     = $clog2(PROG_LEN);

  typedef enum logic [5:0] {
    S_RATEX, S_RATEY, S_RATEZ, S_SPD, S_TS,
    S_PW, S_PX, S_PY, S_PZ,
    S_SX, S_CX, S_SY, S_CY, S_SZ, S_CZ,
    S_AW, S_AX, S_AY, S_AZ,
    S_BW, S_BX, S_BY, S_BZ,
    S_QW, S_QX, S_QY, S_QZ,
    S_R0, S_R1, S_R2,
    S_V0, S_V1, S_V2
  } slot_t;

  localparam int NSLOT = 33;

  typedef enum logic [1:0] {RND30, RND25, RND24} rnd_t;

  typedef enum logic [2:0] {FIN_SAT, FIN_DBL, FIN_ONEM, FIN_POS, FIN_HALF} fin_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_FETCH, ST_ISSUE, ST_MUL, ST_FIN,
    ST_CORD, ST_SIN, ST_COS, ST_COPY, ST_DONE
  } state_t;

  typedef struct packed {
    slot_t       a;
    slot_t       b;
    logic        neg;
    rnd_t        rnd;
    logic        first;
    logic        last;
    fin_t        fin;
    slot_t       dest;
    logic [1:0]  pidx;
  } op_t;

  function automatic logic [31:0] atan_val(input logic [4:0] k);
    logic [31:0] r;
    unique case (k)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > 64'sd140737488355327) r = 48'sh7FFFFFFFFFFF;
    else if (v < -64'sd140737488355328) r = 48'sh800000000000;
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [63:0] round_q(input logic signed [63:0] p,
                                                 input rnd_t c);
    logic signed [63:0] r;
    unique case (c)
      RND30:   r = (p + 64'sd536870912) >>> 30;
      RND25:   r = (p + 64'sd16777216) >>> 25;
      RND24:   r = (p + 64'sd8388608) >>> 24;
      default: r = (p + 64'sd536870912) >>> 30;
    endcase
    return r;
  endfunction

  function automatic op_t mk(input slot_t a, input slot_t b, input logic neg,
                             input rnd_t rnd, input logic first, input logic last,
                             input fin_t fin, input slot_t dest,
                             input logic [1:0] pidx);
    op_t o;
    o.a = a; o.b = b; o.neg = neg; o.rnd = rnd; o.first = first; o.last = last;
    o.fin = fin; o.dest = dest; o.pidx = pidx;
    return o;
  endfunction

  // multiply program: half angles, step quaternion, orientation, rotation,
  // velocity, position
  function automatic op_t prog(input logic [OP_W-1:0] i);
    op_t o;
    unique case (i)
      6'd0:  o = mk(S_RATEX, S_TS, 1'b0, RND25, 1'b1, 1'b1, FIN_HALF, S_SX, 2'd0);
      6'd1:  o = mk(S_RATEY, S_TS, 1'b0, RND25, 1'b1, 1'b1, FIN_HALF, S_SY, 2'd0);
      6'd2:  o = mk(S_RATEZ, S_TS, 1'b0, RND25, 1'b1, 1'b1, FIN_HALF, S_SZ, 2'd0);
      6'd3:  o = mk(S_CX, S_CY, 1'b0, RND30, 1'b1, 1'b1, FIN_SAT, S_AW, 2'd0);
      6'd4:  o = mk(S_SX, S_CY, 1'b0, RND30, 1'b1, 1'b1, FIN_SAT, S_AX, 2'd0);
      6'd5:  o = mk(S_CX, S_SY, 1'b0, RND30, 1'b1, 1'b1, FIN_SAT, S_AY, 2'd0);
      6'd6:  o = mk(S_SX, S_SY, 1'b0, RND30, 1'b1, 1'b1, FIN_SAT, S_AZ, 2'd0);
      6'd7:  o = mk(S_AW, S_CZ, 1'b0, RND30, 1'b1, 1'b0, FIN_SAT, S_BW, 2'd0);
      6'd8:  o = mk(S_AZ, S_SZ, 1'b1, RND30, 1'b0, 1'b1, FIN_SAT, S_BW, 2'd0);
      6'd9:  o = mk(S_AX, S_CZ, 1'b0, RND30, 1'b1, 1'b0, FIN_SAT, S_BX, 2'd0);
      6'd10: o = mk(S_AY, S_SZ, 1'b0, RND30, 1'b0, 1'b1, FIN_SAT, S_BX, 2'd0);
      6'd11: o = mk(S_AY, S_CZ, 1'b0, RND30, 1'b1, 1'b0, FIN_SAT, S_BY, 2'd0);
      6'd12: o = mk(S_AX, S_SZ, 1'b1, RND30, 1'b0, 1'b1, FIN_SAT, S_BY, 2'd0);
      6'd13: o = mk(S_AZ, S_CZ, 1'b0, RND30, 1'b1, 1'b0, FIN_SAT, S_BZ, 2'd0);
      6'd14: o = mk(S_AW, S_SZ, 1'b0, RND30, 1'b0, 1'b1, FIN_SAT, S_BZ, 2'd0);
      6'd15: o = mk(S_PW, S_BW, 1'b0, RND30, 1'b1, 1'b0, FIN_SAT, S_QW, 2'd0);
      6'd16: o = mk(S_PX, S_BX, 1'b1, RND30, 1'b0, 1'b0, FIN_SAT, S_QW, 2'd0);
      6'd17: o = mk(S_PY, S_BY, 1'b1, RND30, 1'b0, 1'b0, FIN_SAT, S_QW, 2'd0);
      6'd18: o = mk(S_PZ, S_BZ, 1'b1, RND30, 1'b0, 1'b1, FIN_SAT, S_QW, 2'd0);
      6'd19: o = mk(S_PW, S_BX, 1'b0, RND30, 1'b1, 1'b0, FIN_SAT, S_QX, 2'd0);
      6'd20: o = mk(S_PX, S_BW, 1'b0, RND30, 1'b0, 1'b0, FIN_SAT, S_QX, 2'd0);
      6'd21: o = mk(S_PY, S_BZ, 1'b0, RND30, 1'b0, 1'b0, FIN_SAT, S_QX, 2'd0);
      6'd22: o = mk(S_PZ, S_BY, 1'b1, RND30, 1'b0, 1'b1, FIN_SAT, S_QX, 2'd0);
      6'd23: o = mk(S_PW, S_BY, 1'b0, RND30, 1'b1, 1'b0, FIN_SAT, S_QY, 2'd0);
      6'd24: o = mk(S_PX, S_BZ, 1'b1, RND30, 1'b0, 1'b0, FIN_SAT, S_QY, 2'd0);
      6'd25: o = mk(S_PY, S_BW, 1'b0, RND30, 1'b0, 1'b0, FIN_SAT, S_QY, 2'd0);
      6'd26: o = mk(S_PZ, S_BX, 1'b0, RND30, 1'b0, 1'b1, FIN_SAT, S_QY, 2'd0);
      6'd27: o = mk(S_PW, S_BZ, 1'b0, RND30, 1'b1, 1'b0, FIN_SAT, S_QZ, 2'd0);
      6'd28: o = mk(S_PX, S_BY, 1'b0, RND30, 1'b0, 1'b0, FIN_SAT, S_QZ, 2'd0);
      6'd29: o = mk(S_PY, S_BX, 1'b1, RND30, 1'b0, 1'b0, FIN_SAT, S_QZ, 2'd0);
      6'd30: o = mk(S_PZ, S_BW, 1'b0, RND30, 1'b0, 1'b1, FIN_SAT, S_QZ, 2'd0);
      6'd31: o = mk(S_QY, S_QY, 1'b0, RND30, 1'b1, 1'b0, FIN_ONEM, S_R0, 2'd0);
      6'd32: o = mk(S_QZ, S_QZ, 1'b0, RND30, 1'b0, 1'b1, FIN_ONEM, S_R0, 2'd0);
      6'd33: o = mk(S_QX, S_QY, 1'b0, RND30, 1'b1, 1'b0, FIN_DBL, S_R1, 2'd0);
      6'd34: o = mk(S_QW, S_QZ, 1'b0, RND30, 1'b0, 1'b1, FIN_DBL, S_R1, 2'd0);
      6'd35: o = mk(S_QX, S_QZ, 1'b0, RND30, 1'b1, 1'b0, FIN_DBL, S_R2, 2'd0);
      6'd36: o = mk(S_QW, S_QY, 1'b1, RND30, 1'b0, 1'b1, FIN_DBL, S_R2, 2'd0);
      6'd37: o = mk(S_SPD, S_R0, 1'b0, RND30, 1'b1, 1'b1, FIN_SAT, S_V0, 2'd0);
      6'd38: o = mk(S_SPD, S_R1, 1'b0, RND30, 1'b1, 1'b1, FIN_SAT, S_V1, 2'd0);
      6'd39: o = mk(S_SPD, S_R2, 1'b0, RND30, 1'b1, 1'b1, FIN_SAT, S_V2, 2'd0);
      6'd40: o = mk(S_V0, S_TS, 1'b0, RND24, 1'b1, 1'b1, FIN_POS, S_V0, 2'd0);
      6'd41: o = mk(S_V1, S_TS, 1'b0, RND24, 1'b1, 1'b1, FIN_POS, S_V1, 2'd1);
      6'd42: o = mk(S_V2, S_TS, 1'b0, RND24, 1'b1, 1'b1, FIN_POS, S_V2, 2'd2);
      default: o = mk(S_V2, S_TS, 1'b0, RND24, 1'b1, 1'b1, FIN_POS, S_V2, 2'd2);
    endcase
    return o;
  endfunction

endpackage

/* rtl/core/qdr_mul.sv */
// ----------------------------------------------------------------------------
// qdr_mul
// Digit-serial signed 32x32 multiplier, one 4-bit digit of the multiplier
// per cycle, least significant first; product low half shifts out serially.
// ----------------------------------------------------------------------------
module qdr_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [31:0]   a,
  input  logic signed [31:0]   b,
  output logic                 done,
  output logic signed [63:0]   product
);
  import qdr_pkg::*;

  logic signed [OPND_W-1:0]   mcand;
  logic [OPND_W-1:0]          mplier;
  logic signed [OPND_W+4:0]   hi;
  logic [OPND_W-1:0]          lo;
  logic [DCNT_W-1:0]          cnt;
  logic                       busy;
  logic                       last_dig;
  logic signed [DIGIT_W:0]    dig;
  logic signed [OPND_W+4:0]   term;
  logic signed [OPND_W+4:0]   sum;

  assign last_dig = (cnt == DCNT_W'(DIGITS - 1));
  assign dig  = last_dig ? $signed({mplier[DIGIT_W-1], mplier[DIGIT_W-1:0]})
                         : $signed({1'b0, mplier[DIGIT_W-1:0]});
  assign term = (OPND_W+5)'(mcand * dig);
  assign sum  = hi + term;
  assign product = {hi[OPND_W-1:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand  <= a;
        mplier <= b;
        hi     <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        hi     <= sum >>> DIGIT_W;
        lo     <= {sum[DIGIT_W-1:0], lo[OPND_W-1:DIGIT_W]};
        mplier <= mplier >> DIGIT_W;
        cnt    <= cnt + 1'b1;
        if (last_dig) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/qdr_cordic.sv */
// ----------------------------------------------------------------------------
// qdr_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving sine
// and cosine of a Q4.30 angle.
// ----------------------------------------------------------------------------
module qdr_cordic #(
  parameter int STEPS = qdr_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [qdr_pkg::CORD_W-1:0] angle,
  output logic                              done,
  output logic signed [qdr_pkg::CORD_W-1:0] sin_out,
  output logic signed [qdr_pkg::CORD_W-1:0] cos_out
);
  import qdr_pkg::*;

  localparam int CNT_W = ($clog2(STEPS + 1) > 5) ? $clog2(STEPS + 1) : 5;

  logic signed [CORD_W-1:0] x, y, z;
  logic signed [CORD_W-1:0] dx, dy, at;
  logic [CNT_W-1:0]         cnt;
  logic [4:0]               k;
  logic                     busy;

  assign k  = cnt[4:0];
  assign dx = y >>> k;
  assign dy = x >>> k;
  assign at = $signed({2'b00, atan_val(k)});
  assign sin_out = y;
  assign cos_out = x;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= angle;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!z[CORD_W-1]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/quaternion_dead_reckoning_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_dead_reckoning_unit
// Quaternion dead-reckoning integrator: one tick in, one pose word out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one tick word: start flag, three
// body rates and forward speed. Output channel (out_valid/out_ready) gives
// position, orientation and world velocity of that tick.
// time_step is written through cfg_wr_en/cfg_wr_data; the user must do so
// only while the unit is idle, as the unit itself does not enforce it.
// A tick runs through a fixed program of 43 products on one 4-bit
// digit-serial multiplier (operand fetch, issue, multiply and finish each)
// and three CORDIC runs, each followed by a sine and a cosine write.
// One tick is in work at a time.
// The finished word sits in an output register, so the next tick is taken
// while the receiver stalls; the unit only waits if a second result is ready
// before the first is taken.
// Reset gives identity orientation, zero position and the default time step;
// start_run does the same for orientation and position at its tick.
// ----------------------------------------------------------------------------
module quaternion_dead_reckoning_unit #(
  parameter int CORDIC_STEPS = qdr_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [23:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               start_run,
  input  logic signed [31:0] rate_x,
  input  logic signed [31:0] rate_y,
  input  logic signed [31:0] rate_z,
  input  logic signed [31:0] speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_y,
  output logic signed [47:0] pos_z,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z
);
  import qdr_pkg::*;

  state_t state, state_next;

  logic [23:0]        time_step;
  logic               lat_start;
  logic               pose_clear;
  logic signed [31:0] lat_rx, lat_ry, lat_rz, lat_spd;
  logic [3:0]         ld_cnt;
  logic [OP_W-1:0]    op;
  logic [1:0]         cp_cnt;
  logic signed [63:0] acc;
  logic               neg;
  logic signed [47:0] pos [3];
  logic signed [31:0] work_quat [4];
  logic signed [31:0] work_vel [3];

  logic [31:0]        mem [NSLOT];
  logic signed [31:0] rd_a, rd_b;
  logic               mem_we;
  slot_t              mem_waddr;
  logic [31:0]        mem_wdata;

  logic               mul_start, mul_done;
  logic signed [63:0] product;
  logic               cord_start, cord_done;
  logic signed [CORD_W-1:0] cord_sin, cord_cos, cord_angle;

  op_t                e;
  logic signed [63:0] rnd, term, acc_sum, hf, pos_sum;
  logic               fold;
  logic signed [31:0] fin_val;
  logic signed [CORD_W-1:0] sin_fix, cos_fix;
  logic               out_take;
  logic               out_load;

  qdr_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(rd_a), .b(rd_b),
    .done(mul_done), .product(product)
  );

  qdr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cord_start), .angle(cord_angle),
    .done(cord_done), .sin_out(cord_sin), .cos_out(cord_cos)
  );

  // datapath of the finish step
  always_comb begin
    e       = prog(op);
    rnd     = round_q(product, e.rnd);
    term    = e.neg ? -rnd : rnd;
    acc_sum = (e.first ? 64'sd0 : acc) + term;
    fold    = 1'b0;
    hf      = rnd;
    if (rnd > HALF_PI_Q28) begin
      hf   = rnd - PI_Q28;
      fold = 1'b1;
    end else if (rnd < -HALF_PI_Q28) begin
      hf   = rnd + PI_Q28;
      fold = 1'b1;
    end
    cord_angle = CORD_W'(hf <<< 2);
    pos_sum    = 64'(pos[e.pidx]) + acc_sum;
    unique case (e.fin)
      FIN_DBL:  fin_val = sat32(acc_sum <<< 1);
      FIN_ONEM: fin_val = sat32(Q30_ONE - (acc_sum <<< 1));
      default:  fin_val = sat32(acc_sum);
    endcase
    sin_fix  = neg ? -cord_sin : cord_sin;
    cos_fix  = neg ? -cord_cos : cord_cos;
    out_take = out_valid && out_ready;
    out_load = (state == ST_DONE) && (!out_valid || out_ready);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_LOAD;
      ST_LOAD:  if (ld_cnt == 4'd8) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_ISSUE;
      ST_ISSUE: state_next = ST_MUL;
      ST_MUL:   if (mul_done) state_next = ST_FIN;
      ST_FIN: begin
        if (e.fin == FIN_HALF) state_next = ST_CORD;
        else if (op == OP_W'(PROG_LEN - 1)) state_next = ST_COPY;
        else state_next = ST_FETCH;
      end
      ST_CORD:  if (cord_done) state_next = ST_SIN;
      ST_SIN:   state_next = ST_COS;
      ST_COS:   state_next = ST_FETCH;
      ST_COPY:  if (cp_cnt == 2'd3) state_next = ST_DONE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs and store write port
  always_comb begin
    in_ready   = 1'b0;
    mul_start  = 1'b0;
    cord_start = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = S_TS;
    mem_wdata  = '0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_LOAD: begin
        mem_we = 1'b1;
        unique case (ld_cnt)
          4'd0: begin mem_waddr = S_RATEX; mem_wdata = lat_rx;  end
          4'd1: begin mem_waddr = S_RATEY; mem_wdata = lat_ry;  end
          4'd2: begin mem_waddr = S_RATEZ; mem_wdata = lat_rz;  end
          4'd3: begin mem_waddr = S_SPD;   mem_wdata = lat_spd; end
          4'd4: begin mem_waddr = S_TS;    mem_wdata = {8'd0, time_step}; end
          4'd5: begin
            mem_we = lat_start; mem_waddr = S_PW; mem_wdata = Q30_ONE[31:0];
          end
          4'd6: begin mem_we = lat_start; mem_waddr = S_PX; end
          4'd7: begin mem_we = lat_start; mem_waddr = S_PY; end
          default: begin mem_we = lat_start; mem_waddr = S_PZ; end
        endcase
      end
      ST_ISSUE: mul_start = 1'b1;
      ST_FIN: begin
        cord_start = (e.fin == FIN_HALF);
        mem_we     = e.last && (e.fin != FIN_HALF) && (e.fin != FIN_POS);
        mem_waddr  = e.dest;
        mem_wdata  = fin_val;
      end
      ST_SIN: begin
        mem_we = 1'b1; mem_waddr = e.dest; mem_wdata = sin_fix[31:0];
      end
      ST_COS: begin
        mem_we = 1'b1; mem_waddr = slot_t'(e.dest + 6'd1); mem_wdata = cos_fix[31:0];
      end
      ST_COPY: begin
        mem_we    = 1'b1;
        mem_waddr = slot_t'(S_PW + {4'd0, cp_cnt});
        mem_wdata = work_quat[cp_cnt];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (state == ST_FETCH) begin
      rd_a <= mem[e.a];
      rd_b <= mem[e.b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      time_step  <= TIME_STEP_RESET;
      out_valid  <= 1'b0;
      pose_clear <= 1'b1;
      ld_cnt     <= '0;
      op         <= '0;
      cp_cnt     <= '0;
      pos[0]     <= '0;
      pos[1]     <= '0;
      pos[2]     <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) time_step <= cfg_wr_data;
      out_valid <= out_load || (out_valid && !out_take);
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            lat_start  <= start_run || pose_clear;
            pose_clear <= 1'b0;
            lat_rx     <= rate_x;
            lat_ry     <= rate_y;
            lat_rz     <= rate_z;
            lat_spd    <= speed;
            ld_cnt     <= '0;
            op         <= '0;
            if (start_run) begin
              pos[0] <= '0;
              pos[1] <= '0;
              pos[2] <= '0;
            end
          end
        end
        ST_LOAD: ld_cnt <= ld_cnt + 1'b1;
        ST_FIN: begin
          acc <= acc_sum;
          if (e.fin == FIN_HALF) neg <= fold;
          else op <= op + 1'b1;
          if (e.fin == FIN_POS) pos[e.pidx] <= sat48(pos_sum);
          if (e.last) begin
            unique case (e.dest)
              S_QW: work_quat[0] <= fin_val;
              S_QX: work_quat[1] <= fin_val;
              S_QY: work_quat[2] <= fin_val;
              S_QZ: work_quat[3] <= fin_val;
              S_V0: if (e.fin != FIN_POS) work_vel[0] <= fin_val;
              S_V1: if (e.fin != FIN_POS) work_vel[1] <= fin_val;
              S_V2: if (e.fin != FIN_POS) work_vel[2] <= fin_val;
              default: ;
            endcase
          end
          cp_cnt <= '0;
        end
        ST_COS:  op <= op + 1'b1;
        ST_COPY: cp_cnt <= cp_cnt + 1'b1;
        ST_DONE: begin
          if (out_load) begin
            pos_x  <= pos[0];
            pos_y  <= pos[1];
            pos_z  <= pos[2];
            quat_w <= work_quat[0];
            quat_x <= work_quat[1];
            quat_y <= work_quat[2];
            quat_z <= work_quat[3];
            vel_x  <= work_vel[0];
            vel_y  <= work_vel[1];
            vel_z  <= work_vel[2];
          end
        end
        default: ;
      endcase
    end
  end

endmodule
